/* src/i2cte_pkg.sv */
// i2cte_pkg: shared types and codes for the i2c target edge engine
// no dependencies; used by i2cte_core and i2c_target_edge_engine
package i2cte_pkg;

  localparam int unsigned AddrW  = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 5;

  // scl edge counts: last data bit, ack fall, wrap point
  localparam logic [CountW-1:0] LastBitEdge = CountW'(15);
  localparam logic [CountW-1:0] AckEdge     = CountW'(16);
  localparam logic [CountW-1:0] WrapEdge    = CountW'(17);

  typedef enum logic [1:0] {
    KIND_SCL_FALL = 2'd0,
    KIND_SCL_RISE = 2'd1,
    KIND_SDA_FALL = 2'd2,
    KIND_SDA_RISE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_ADDRESS      = 2'd1,
    PH_RECEIVING    = 2'd2,
    PH_TRANSMITTING = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ADDR_HIT  = 3'd1,
    EV_RX_BYTE   = 3'd2,
    EV_STOP      = 3'd3,
    EV_TX_LOADED = 3'd4
  } event_e;

  typedef struct packed {
    kind_e             kind;
    logic              sda_level;
    logic              scl_level;
    logic              ack_byte;
    logic [ByteW-1:0]  tx_byte;
  } item_t;

  typedef struct packed {
    logic              sda_out;
    event_e            event_res;
    logic              event_read;
    logic              event_restart;
    logic [ByteW-1:0]  rx_byte;
  } result_t;

endpackage

/* src/i2c_target_edge_engine.sv */
// i2c_target_edge_engine: top level with input beat register, result register
// and address register; depends on i2cte_pkg and i2cte_core
//
// Bus-edge driven I2C target with a 7-bit address. Each input beat is one
// edge event (scl fall/rise, sda fall/rise) with the sampled line levels; each
// beat yields exactly one result beat with the sda drive level and an event
// code (address match, data byte, stop, transmit byte loaded). Throughput is
// one beat per clock while out_stall_i stays low: a beat is held in the input
// register, the protocol state is updated in a single pass of logic and the
// result lands in the output register, which drives out_valid_o. The input
// side keeps taking beats while a result waits to be taken, as long as the
// result register frees up in the same cycle; with the result stalled one
// more beat is held in the input register before in_stall_o rises. own_address
// is written through the cfg channel, which is always ready; write it only
// while no beat is in flight.
module i2c_target_edge_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [i2cte_pkg::AddrW-1:0]    cfg_own_address_i,
  // edge event beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  input  logic                           sda_level_i,
  input  logic                           scl_level_i,
  input  logic                           ack_byte_i,
  input  logic [i2cte_pkg::ByteW-1:0]    tx_byte_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           sda_out_o,
  output logic [2:0]                     event_res_o,
  output logic                           event_read_o,
  output logic                           event_restart_o,
  output logic [i2cte_pkg::ByteW-1:0]    rx_byte_o
);
  import i2cte_pkg::*;

  logic [AddrW-1:0] own_addr_q;
  logic             in_vld_q, in_vld_d;
  item_t            item_q;
  logic             out_vld_q, out_vld_d;
  result_t          res_q, res_d;
  logic             in_accept;
  logic             advance;

  // the one configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      own_addr_q <= cfg_own_address_i;
    end
  end

  // the held beat moves on when the result register is empty or being drained
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{kind: kind_e'(kind_i), sda_level: sda_level_i,
                  scl_level: scl_level_i, ack_byte: ack_byte_i, tx_byte: tx_byte_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // protocol state and per-edge logic
  i2cte_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (advance),
    .item_i        (item_q),
    .own_address_i (own_addr_q),
    .result_o      (res_d)
  );

  assign out_valid_o     = out_vld_q;
  assign sda_out_o       = res_q.sda_out;
  assign event_res_o     = res_q.event_res;
  assign event_read_o    = res_q.event_read;
  assign event_restart_o = res_q.event_restart;
  assign rx_byte_o       = res_q.rx_byte;

endmodule

/* src/i2cte_core.sv */
// i2cte_core: bus protocol state and one-pass next-state logic per edge beat
// depends on i2cte_pkg
module i2cte_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  i2cte_pkg::item_t               item_i,
  input  logic [i2cte_pkg::AddrW-1:0]    own_address_i,
  output i2cte_pkg::result_t             result_o
);
  import i2cte_pkg::*;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                in_xfer_q, in_xfer_d;
  logic                rstart_q, rstart_d;
  logic                ack_pend_q, ack_pend_d;
  logic [ByteW-1:0]    rx_q, rx_d;
  logic [ByteW-1:0]    tx_q, tx_d;
  logic                sda_q, sda_d;

  always_comb begin
    logic   rise;
    phase_e ph_old;
    phase_d    = phase_q;
    count_d    = count_q;
    in_xfer_d  = in_xfer_q;
    rstart_d   = rstart_q;
    ack_pend_d = ack_pend_q;
    rx_d       = rx_q;
    tx_d       = tx_q;
    sda_d      = sda_q;
    result_o   = '{sda_out: 1'b1, event_res: EV_NONE, event_read: 1'b0,
                   event_restart: 1'b0, rx_byte: '0};
    rise       = (item_i.kind == KIND_SCL_RISE);
    ph_old     = phase_q;

    case (item_i.kind)
      KIND_SCL_FALL, KIND_SCL_RISE: begin
        if (in_xfer_q) begin
          if (count_q == '0 && phase_q != PH_TRANSMITTING) begin
            sda_d = 1'b1;
            rx_d  = '0;
          end
          if (count_q == AckEdge) begin
            if (ack_pend_q) begin
              sda_d      = 1'b0;
              ack_pend_d = 1'b0;
            end else begin
              sda_d = 1'b1;
            end
          end
          if (count_q < AckEdge && rise) begin
            rx_d = {rx_d[ByteW-2:0], item_i.sda_level};
          end
          if (count_q == LastBitEdge) begin
            if (ph_old == PH_RECEIVING) begin
              ack_pend_d         = item_i.ack_byte;
              result_o.event_res = EV_RX_BYTE;
              result_o.rx_byte   = rx_d;
            end else if (ph_old == PH_ADDRESS) begin
              if (rx_d[ByteW-1:1] == own_address_i) begin
                ack_pend_d             = 1'b1;
                result_o.event_res     = EV_ADDR_HIT;
                result_o.event_read    = rx_d[0];
                result_o.event_restart = rstart_q;
                result_o.rx_byte       = rx_d;
                phase_d = rx_d[0] ? PH_TRANSMITTING : PH_RECEIVING;
              end else begin
                phase_d   = PH_IDLE;
                in_xfer_d = 1'b0;
                rstart_d  = 1'b0;
              end
            end
          end
          if (phase_d == PH_TRANSMITTING) begin
            if (count_q == '0) begin
              tx_d               = item_i.tx_byte;
              result_o.event_res = EV_TX_LOADED;
            end
            if (count_q < AckEdge && !rise) begin
              sda_d = tx_d[ByteW-1];
              tx_d  = {tx_d[ByteW-2:0], 1'b0};
            end
          end
          count_d = (count_q == WrapEdge) ? '0 : count_q + CountW'(1);
        end
      end
      KIND_SDA_FALL: begin
        // start or repeated start
        if (item_i.scl_level) begin
          if (in_xfer_q) rstart_d = 1'b1;
          count_d    = '0;
          ack_pend_d = 1'b0;
          rx_d       = '0;
          in_xfer_d  = 1'b1;
          phase_d    = PH_ADDRESS;
        end
      end
      default: begin
        // stop
        if (item_i.scl_level && in_xfer_q) begin
          phase_d            = PH_IDLE;
          in_xfer_d          = 1'b0;
          rstart_d           = 1'b0;
          result_o.event_res = EV_STOP;
        end
      end
    endcase
    result_o.sda_out = sda_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      count_q    <= '0;
      in_xfer_q  <= 1'b0;
      rstart_q   <= 1'b0;
      ack_pend_q <= 1'b0;
      rx_q       <= '0;
      tx_q       <= '0;
      sda_q      <= 1'b1;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      in_xfer_q  <= in_xfer_d;
      rstart_q   <= rstart_d;
      ack_pend_q <= ack_pend_d;
      rx_q       <= rx_d;
      tx_q       <= tx_d;
      sda_q      <= sda_d;
    end
  end

endmodule

/* tb/i2c_target_edge_engine_tb.sv */
// i2c_target_edge_engine_tb: self-checking bench for the bus-edge i2c target engine
// drives edge events through the in/out stall handshakes and checks each result beat
// against a cycle-free model of the protocol state; depends on i2cte_pkg and i2c_target_edge_engine
`timescale 1ns / 1ps

module i2c_target_edge_engine_tb;
  import i2cte_pkg::*;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned PhaseBeats  = 210;
  localparam int unsigned QuietFrom   = 400;
  localparam int unsigned QuietTo     = 700;
  localparam int unsigned HoldAt      = 900;
  localparam int unsigned HoldCycles  = 60;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [AddrW-1:0] cfg_own_address_i;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [1:0]       kind_i      = KIND_SCL_FALL;
  logic             sda_level_i = 1'b1;
  logic             scl_level_i = 1'b1;
  logic             ack_byte_i  = 1'b0;
  logic [ByteW-1:0] tx_byte_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             sda_out_o;
  logic [2:0]       event_res_o;
  logic             event_read_o;
  logic             event_restart_o;
  logic [ByteW-1:0] rx_byte_o;

  i2c_target_edge_engine i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_own_address_i (cfg_own_address_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .sda_level_i       (sda_level_i),
    .scl_level_i       (scl_level_i),
    .ack_byte_i        (ack_byte_i),
    .tx_byte_i         (tx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sda_out_o         (sda_out_o),
    .event_res_o       (event_res_o),
    .event_read_o      (event_read_o),
    .event_restart_o   (event_restart_o),
    .rx_byte_o         (rx_byte_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // protocol model: own copy of the target state, advanced once per accepted beat
  // ---------------------------------------------------------------------------
  logic [AddrW-1:0]  own_addr   = '0;
  phase_e            bus_phase  = PH_IDLE;
  logic [CountW-1:0] scl_count  = '0;
  logic              xfer_open  = 1'b0;
  logic              restarted  = 1'b0;
  logic              ack_owed   = 1'b0;
  logic [ByteW-1:0]  rx_shreg   = '0;
  logic [ByteW-1:0]  tx_shreg   = '0;
  logic              sda_drive  = 1'b1;

  // works out the line response to one edge event and moves the state on
  task automatic predict_line_response(input item_t ev_in, output result_t resp);
    logic rising;
    resp   = '0;
    rising = (ev_in.kind == KIND_SCL_RISE);
    case (ev_in.kind)
      KIND_SCL_FALL, KIND_SCL_RISE: begin
        // scl edges only count while a transfer is open
        if (xfer_open) begin
          // start of a bit slot: release the line unless we are sending
          if (scl_count == '0 && bus_phase != PH_TRANSMITTING) begin
            sda_drive = 1'b1;
            rx_shreg  = '0;
          end
          // ack fall: pull low if an acknowledge is owed, else release
          if (scl_count == AckEdge) begin
            if (ack_owed) begin
              sda_drive = 1'b0;
              ack_owed  = 1'b0;
            end else begin
              sda_drive = 1'b1;
            end
          end
          if (scl_count < AckEdge && rising) begin
            rx_shreg = {rx_shreg[ByteW-2:0], ev_in.sda_level};
          end
          // byte complete on the last data rise
          if (scl_count == LastBitEdge) begin
            if (bus_phase == PH_RECEIVING) begin
              ack_owed        = ev_in.ack_byte;
              resp.event_res  = EV_RX_BYTE;
              resp.rx_byte    = rx_shreg;
            end
            if (bus_phase == PH_ADDRESS) begin
              if (rx_shreg[ByteW-1:1] == own_addr) begin
                ack_owed           = 1'b1;
                resp.event_res     = EV_ADDR_HIT;
                resp.event_read    = rx_shreg[0];
                resp.event_restart = restarted;
                resp.rx_byte       = rx_shreg;
                bus_phase          = rx_shreg[0] ? PH_TRANSMITTING : PH_RECEIVING;
              end else begin
                // not for us: drop out, sda stays as it was
                bus_phase = PH_IDLE;
                xfer_open = 1'b0;
                restarted = 1'b0;
              end
            end
          end
          // transmit: load at the slot start, shift out msb first on falls
          if (bus_phase == PH_TRANSMITTING) begin
            if (scl_count == '0) begin
              tx_shreg       = ev_in.tx_byte;
              resp.event_res = EV_TX_LOADED;
            end
            if (scl_count < AckEdge && !rising) begin
              sda_drive = tx_shreg[ByteW-1];
              tx_shreg  = {tx_shreg[ByteW-2:0], 1'b0};
            end
          end
          scl_count = (scl_count == WrapEdge) ? '0 : scl_count + CountW'(1);
        end
      end
      KIND_SDA_FALL: begin
        // start or repeated start; sda drive left alone
        if (ev_in.scl_level) begin
          if (xfer_open) restarted = 1'b1;
          scl_count = '0;
          ack_owed  = 1'b0;
          rx_shreg  = '0;
          xfer_open = 1'b1;
          bus_phase = PH_ADDRESS;
        end
      end
      default: begin
        // stop only counts inside a transfer
        if (ev_in.scl_level && xfer_open) begin
          bus_phase      = PH_IDLE;
          xfer_open      = 1'b0;
          restarted      = 1'b0;
          resp.event_res = EV_STOP;
        end
      end
    endcase
    resp.sda_out = sda_drive;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus queues and shared counters
  // ---------------------------------------------------------------------------
  item_t   edge_q[$];          // edge events waiting to be offered
  result_t line_resp_q[$];     // predicted result beats, oldest first
  int unsigned queued_beats = 0;
  int unsigned beats_in     = 0;
  int unsigned cycles       = 0;
  int unsigned fail_count   = 0;
  bit          in_fire      = 1'b0;
  bit          hold_off     = 1'b0;

  // random idling, switched off for a stretch in the middle of the run
  function automatic bit take_break();
    if (beats_in >= QuietFrom && beats_in < QuietTo) return 1'b0;
    return $urandom_range(99) < 25;
  endfunction

  task automatic queue_edge(input kind_e k, input logic sda, input logic scl);
    item_t ev;
    ev.kind      = k;
    ev.sda_level = sda;
    ev.scl_level = scl;
    ev.ack_byte  = 1'($urandom_range(1));
    ev.tx_byte   = 8'($urandom_range(255));
    edge_q.push_back(ev);
    queued_beats++;
  endtask

  // one byte slot as scl fall/rise pairs, eight data bits then the ack bit;
  // fewer pairs leave the byte cut short
  task automatic queue_byte(input logic [ByteW-1:0] val, input int unsigned pairs);
    logic bitv;
    for (int unsigned i = 0; i < pairs && i < 9; i++) begin
      bitv = (i < 8) ? val[7-i] : 1'($urandom_range(1));
      queue_edge(KIND_SCL_FALL, 1'($urandom_range(1)), 1'b0);
      // the master moving sda while scl is low, which the target must ignore
      if ($urandom_range(7) == 0) begin
        queue_edge(bitv ? KIND_SDA_RISE : KIND_SDA_FALL, bitv, 1'b0);
      end
      queue_edge(KIND_SCL_RISE, bitv, 1'b1);
    end
  endtask

  // start, address, a few data bytes, then stop or straight into a repeated start
  task automatic queue_transfer();
    logic [AddrW-1:0] target;
    logic             rd;
    int unsigned      nbytes;
    target = ($urandom_range(9) < 8) ? own_addr : AddrW'($urandom_range(127));
    rd     = 1'($urandom_range(1));
    nbytes = $urandom_range(4);
    queue_edge(KIND_SDA_FALL, 1'b0, 1'b1);
    if ($urandom_range(9) == 0) begin
      queue_byte({target, rd}, $urandom_range(1, 8));
    end else begin
      queue_byte({target, rd}, 9);
      repeat (nbytes) queue_byte(8'($urandom_range(255)), 9);
      if ($urandom_range(5) == 0) queue_byte(8'($urandom_range(255)), $urandom_range(1, 8));
    end
    if ($urandom_range(3) != 0) queue_edge(KIND_SDA_RISE, 1'b1, 1'b1);
  endtask

  task automatic write_own_address(input logic [AddrW-1:0] addr);
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_own_address_i <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    own_addr = addr;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // every beat gives exactly one result, so an empty prediction queue means idle
  task automatic wait_drained();
    do @(posedge clk_i); while (edge_q.size() != 0 || in_valid_i || line_resp_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // sender: offers the next edge event at the falling edge, holds it until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (edge_q.size() != 0 && !take_break()) begin
        item_t nxt;
        nxt = edge_q.pop_front();
        kind_i      <= nxt.kind;
        sda_level_i <= nxt.sda_level;
        scl_level_i <= nxt.scl_level;
        ack_byte_i  <= nxt.ack_byte;
        tx_byte_i   <= nxt.tx_byte;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus the long hold-off
  always @(negedge clk_i) begin
    out_stall_i <= hold_off || take_break();
  end

  // long receiver hold-off while the sender keeps offering, so the engine backs up
  initial begin
    wait (beats_in >= HoldAt);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: checks result beats, then predicts for the input beat taken this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    item_t   taken;
    in_fire = in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (line_resp_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = line_resp_q.pop_front();
        if (sda_out_o !== want.sda_out) begin
          $error("sda_out: expected %0d, got %0d", want.sda_out, sda_out_o);
          fail_count++;
        end
        if (event_res_o !== want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, event_res_o);
          fail_count++;
        end
        if (event_read_o !== want.event_read) begin
          $error("event_read: expected %0d, got %0d", want.event_read, event_read_o);
          fail_count++;
        end
        if (event_restart_o !== want.event_restart) begin
          $error("event_restart: expected %0d, got %0d", want.event_restart, event_restart_o);
          fail_count++;
        end
        if (rx_byte_o !== want.rx_byte) begin
          $error("rx_byte: expected %0d, got %0d", want.rx_byte, rx_byte_o);
          fail_count++;
        end
      end
    end
    if (rst_ni && in_fire) begin
      taken.kind      = kind_e'(kind_i);
      taken.sda_level = sda_level_i;
      taken.scl_level = scl_level_i;
      taken.ack_byte  = ack_byte_i;
      taken.tx_byte   = tx_byte_i;
      predict_line_response(taken, want);
      line_resp_q.push_back(want);
      beats_in++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [AddrW-1:0] addr;
    int unsigned      mark;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_own_address_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: top address, idle edges, stray stop, early stop, then a read
    write_own_address(7'h7F);
    queue_edge(KIND_SCL_RISE, 1'b1, 1'b1);   // scl edge with no transfer open
    queue_edge(KIND_SDA_FALL, 1'b0, 1'b0);   // sda edge with scl low
    queue_edge(KIND_SDA_RISE, 1'b1, 1'b1);   // stop outside a transfer
    queue_edge(KIND_SDA_FALL, 1'b0, 1'b1);   // start
    queue_edge(KIND_SDA_RISE, 1'b1, 1'b1);   // stop in the address byte
    queue_edge(KIND_SDA_FALL, 1'b0, 1'b1);
    queue_byte(8'hFF, 9);                    // matching read address, acked
    queue_edge(KIND_SCL_FALL, 1'b0, 1'b0);   // first transmit byte loaded
    queue_edge(KIND_SDA_RISE, 1'b1, 1'b1);
    wait_drained();

    // random phases, address register swept across its range and extremes
    for (int p = 0; p < 5; p++) begin
      addr = (p == 0) ? 7'h00 : (p == 4) ? 7'h7F : AddrW'($urandom_range(127));
      write_own_address(addr);
      mark = queued_beats;
      while (queued_beats - mark < PhaseBeats) begin
        if ($urandom_range(9) == 0) begin
          // noise: fully random beats
          repeat ($urandom_range(1, 6)) begin
            queue_edge(kind_e'($urandom_range(3)), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
          end
        end else begin
          queue_transfer();
        end
      end
      // close any open transfer so the next address applies from a clean start
      queue_edge(KIND_SDA_RISE, 1'b1, 1'b1);
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
